// ===== hdl/pl0_pkg.sv =====
// ----------------------------------------------------------------------------
// pl0_pkg: shared types and constants for the PL/0 p-machine step block
// Opcodes, sub-operation codes, status codes, payload structs and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package pl0_pkg;

   localparam int STACK_DEPTH_DEF = 2048;
   localparam int CODE_DEPTH_DEF  = 512;
   localparam int LEVELS_DEF      = 3;

   // opcodes
   localparam logic [3:0] OP_LIT = 4'd1;
   localparam logic [3:0] OP_OPR = 4'd2;
   localparam logic [3:0] OP_LOD = 4'd3;
   localparam logic [3:0] OP_STO = 4'd4;
   localparam logic [3:0] OP_CAL = 4'd5;
   localparam logic [3:0] OP_INC = 4'd6;
   localparam logic [3:0] OP_JMP = 4'd7;
   localparam logic [3:0] OP_JPC = 4'd8;
   localparam logic [3:0] OP_SIO = 4'd9;

   // OPR sub-operations
   localparam logic [15:0] OPR_RET = 16'd0;
   localparam logic [15:0] OPR_NEG = 16'd1;
   localparam logic [15:0] OPR_ADD = 16'd2;
   localparam logic [15:0] OPR_SUB = 16'd3;
   localparam logic [15:0] OPR_MUL = 16'd4;
   localparam logic [15:0] OPR_DIV = 16'd5;
   localparam logic [15:0] OPR_ODD = 16'd6;
   localparam logic [15:0] OPR_MOD = 16'd7;
   localparam logic [15:0] OPR_EQL = 16'd8;
   localparam logic [15:0] OPR_NEQ = 16'd9;
   localparam logic [15:0] OPR_LSS = 16'd10;
   localparam logic [15:0] OPR_LEQ = 16'd11;
   localparam logic [15:0] OPR_GTR = 16'd12;
   localparam logic [15:0] OPR_GEQ = 16'd13;

   // SIO sub-operations
   localparam logic [15:0] SIO_WRITE = 16'd0;
   localparam logic [15:0] SIO_READ  = 16'd1;
   localparam logic [15:0] SIO_HALT  = 16'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIVZ  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [1:0]  level;
      logic [15:0] operand;
      logic [31:0] read_value;
   } req_type;

   typedef struct packed {
      logic [8:0]  next_pc;
      logic [10:0] stack_top;
      logic [10:0] frame_base;
      logic        out_valid;
      logic [31:0] out_value;
      logic        halted;
      logic [1:0]  status;
   } rsp_type;

   // datapath address select
   localparam logic [2:0] AS_SP   = 3'd0;
   localparam logic [2:0] AS_SPM1 = 3'd1;
   localparam logic [2:0] AS_LINK = 3'd2;
   localparam logic [2:0] AS_BM   = 3'd3;
   localparam logic [2:0] AS_BP2  = 3'd4;
   localparam logic [2:0] AS_BP3  = 3'd5;
   localparam logic [2:0] AS_CLR  = 3'd6;

   // datapath capture targets
   localparam logic [2:0] CP_NONE = 3'd0;
   localparam logic [2:0] CP_X    = 3'd1;
   localparam logic [2:0] CP_Y    = 3'd2;
   localparam logic [2:0] CP_B    = 3'd3;

   typedef struct packed {
      logic       load;       // latch request, reset walk state
      logic       rd_en;      // issue read
      logic [2:0] rd_sel;
      logic [2:0] cap;        // capture read data (read issued the cycle before)
      logic       div_start;
      logic       exec;       // commit the instruction
      logic       wr_step;    // next CAL frame word write
      logic       clr_step;   // clearing sweep write
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       link_bad;   // next link address out of range
      logic       div_busy;
      logic       clr_done;
      logic       wr_done;
      logic       halt;
   } sts_type;

endpackage

// ===== hdl/pl0_stack_machine_step.sv =====
// ----------------------------------------------------------------------------
// pl0_stack_machine_step: PL/0 p-machine, one instruction per item
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one instruction item (opcode, level, operand, read_value);
//   it is accepted when req_valid is high and req_stall low.
//   rsp_ returns one result item per instruction: next pc, sp, bp, the
//   SIO write value, the halt flag and a status code.
// Sequence: static link walk (LOD, STO, CAL), the operand reads, the
//   radix-2 divider for DIV/MOD, commit, then the CAL frame writes
//   through the single stack write port. One item at a time; the next
//   item is taken the cycle after the result item is accepted.
// Reset: pc 0, bp 1, sp 0, not halted; then a clearing pass writes zero
//   to every stack word, with req_stall high.
// Stall: while rsp_stall holds, the result stays in the output register
//   and no new item is taken.
// After a halt or fault every item returns the unchanged registers.
// ----------------------------------------------------------------------------
module pl0_stack_machine_step import pl0_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
   parameter int LEVELS      = LEVELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   pl0_ctrl #(.LEVELS(LEVELS)) u_ctrl (
      .clock(clock), .reset(reset), .req(req_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   pl0_dp #(.STACK_DEPTH(STACK_DEPTH), .CODE_DEPTH(CODE_DEPTH), .LEVELS(LEVELS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data),
      .cmd(cmd), .sts(sts), .rsp(rsp_data)
   );
endmodule

// ===== hdl/pl0_div.sv =====
// ----------------------------------------------------------------------------
// pl0_div: signed 32-bit radix-2 divider
// Truncating quotient and remainder with the sign of the dividend, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pl0_div import pl0_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        nq_ff, nq_in, nr_ff, nr_in;
   logic [32:0] trial;
   logic [31:0] rsh;

   assign rsh   = {r_ff[30:0], q_ff[31]};
   assign trial = {1'b0, rsh} - {1'b0, d_ff};

   // shift-subtract on magnitudes
   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      nq_in  = nq_ff;
      nr_in  = nr_ff;
      if (start) begin
         cnt_in = 6'd32;
         q_in   = dividend[31] ? 32'd0 - dividend : dividend;
         d_in   = divisor[31] ? 32'd0 - divisor : divisor;
         r_in   = 32'd0;
         nq_in  = dividend[31] ^ divisor[31];
         nr_in  = dividend[31];
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = rsh;
            q_in = {q_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff  <= q_in;
      r_ff  <= r_in;
      d_ff  <= d_in;
      nq_ff <= nq_in;
      nr_ff <= nr_in;
   end

   assign busy      = (cnt_ff != 6'd0);
   assign quotient  = nq_ff ? 32'd0 - q_ff : q_ff;
   assign remainder = nr_ff ? 32'd0 - r_ff : r_ff;
endmodule

// ===== hdl/pl0_dp.sv =====
// ----------------------------------------------------------------------------
// pl0_dp: p-machine datapath
// Stack memory, pc/bp/sp/halt registers, operand registers, ALU, divider
// and result register. Driven by the controller through cmd_type.
// ----------------------------------------------------------------------------
module pl0_dp import pl0_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int CODE_DEPTH  = CODE_DEPTH_DEF,
   parameter int LEVELS      = LEVELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(CODE_DEPTH);
   localparam int LW = $clog2(LEVELS + 1);

   logic [31:0]   mem [STACK_DEPTH];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] raddr;

   req_type       rq_ff;
   logic [CW-1:0] pc_ff;
   logic [AW-1:0] bp_ff, sp_ff;
   logic          halt_ff;
   logic [31:0]   x_ff, y_ff;
   logic [33:0]   b_ff;           // walked base, signed
   logic [LW-1:0] lev_ff;
   logic [1:0]    wcnt_ff;
   logic [AW:0]   clr_ff;
   rsp_type       rsp_ff;

   logic [LW-1:0] lev_cl;
   logic [33:0]   spx, bpx, bm;

   logic          div_busy;
   logic [31:0]   quo, rem;

   pl0_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(x_ff), .divisor(y_ff),
      .busy(div_busy), .quotient(quo), .remainder(rem)
   );

   function automatic logic in_rng(input logic [33:0] a);
      return !a[33] && (a < 34'(STACK_DEPTH));
   endfunction

   assign lev_cl = (34'(rq_ff.level) > 34'(LEVELS)) ? LW'(LEVELS) : LW'(rq_ff.level);
   assign spx = 34'(sp_ff);
   assign bpx = 34'(bp_ff);
   assign bm  = b_ff + 34'(rq_ff.operand);

   // read address select
   always_comb begin
      unique case (cmd.rd_sel)
         AS_SP:   raddr = sp_ff;
         AS_SPM1: raddr = sp_ff - AW'(1);
         AS_LINK: raddr = AW'(b_ff + 34'd1);
         AS_BM:   raddr = AW'(bm);
         AS_BP2:  raddr = bp_ff + AW'(2);
         AS_BP3:  raddr = bp_ff + AW'(3);
         default: raddr = sp_ff;
      endcase
   end

   // ------------------------------------------------------------------
   // execution: compute fault, new registers and memory write
   // ------------------------------------------------------------------
   logic          fault_r, fault_d, we;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;
   logic [33:0]   nsp, nbp;
   logic [CW-1:0] npc, pcn;
   logic          hlt, ov;
   logic [31:0]   oval, r, t;
   logic signed [31:0] sx, sy;
   logic [31:0]   prod;

   assign sx   = x_ff;
   assign sy   = y_ff;
   assign prod = x_ff * y_ff;
   assign pcn  = pc_ff + CW'(1);
   assign t    = rdata_ff;       // top word or loaded word in exec cycle

   always_comb begin
      fault_r = 1'b0; fault_d = 1'b0; we = 1'b0;
      waddr = sp_ff; wdata = 32'd0;
      nsp = spx; nbp = bpx; npc = pcn;
      hlt = 1'b0; ov = 1'b0; oval = 32'd0; r = 32'd0;
      unique case (rq_ff.opcode)
         OP_LIT: begin
            if (!in_rng(spx + 34'd1)) fault_r = 1'b1;
            nsp = spx + 34'd1; we = 1'b1; waddr = AW'(nsp);
            wdata = 32'(rq_ff.operand);
         end
         OP_OPR: begin
            case (rq_ff.operand)
               OPR_RET: begin
                  if (!in_rng(bpx - 34'd1) || !in_rng(bpx + 34'd3)
                      || !in_rng({{2{x_ff[31]}}, x_ff})) fault_r = 1'b1;
                  npc = CW'(y_ff);
                  nsp = bpx - 34'd1;
                  nbp = {{2{x_ff[31]}}, x_ff};
               end
               OPR_NEG: begin
                  we = 1'b1; wdata = 32'd0 - y_ff;
               end
               OPR_ODD: begin
                  we = 1'b1; wdata = {31'd0, y_ff[0]};
               end
               default: begin
                  if (rq_ff.operand <= OPR_GEQ) begin
                     if (!in_rng(spx - 34'd1)) fault_r = 1'b1;
                     else if ((rq_ff.operand == OPR_DIV || rq_ff.operand == OPR_MOD)
                              && y_ff == 32'd0) fault_d = 1'b1;
                     case (rq_ff.operand)
                        OPR_ADD: r = x_ff + y_ff;
                        OPR_SUB: r = x_ff - y_ff;
                        OPR_MUL: r = prod;
                        OPR_DIV: r = quo;
                        OPR_MOD: r = rem;
                        OPR_EQL: r = {31'd0, sx == sy};
                        OPR_NEQ: r = {31'd0, sx != sy};
                        OPR_LSS: r = {31'd0, sx < sy};
                        OPR_LEQ: r = {31'd0, sx <= sy};
                        OPR_GTR: r = {31'd0, sx > sy};
                        default: r = {31'd0, sx >= sy};
                     endcase
                     nsp = spx - 34'd1; we = 1'b1; waddr = AW'(nsp); wdata = r;
                  end
               end
            endcase
         end
         OP_LOD: begin
            if (!in_rng(bm) || !in_rng(spx + 34'd1)) fault_r = 1'b1;
            nsp = spx + 34'd1; we = 1'b1; waddr = AW'(nsp); wdata = t;
         end
         OP_STO: begin
            if (!in_rng(bm) || !in_rng(spx - 34'd1)) fault_r = 1'b1;
            nsp = spx - 34'd1; we = 1'b1; waddr = AW'(bm); wdata = y_ff;
         end
         OP_CAL: begin
            if (!in_rng(spx + 34'd4)) fault_r = 1'b1;
            nbp = spx + 34'd1; npc = CW'(rq_ff.operand);
         end
         OP_INC: begin
            nsp = spx + 34'(rq_ff.operand);
            if (!in_rng(nsp)) fault_r = 1'b1;
         end
         OP_JMP: npc = CW'(rq_ff.operand);
         OP_JPC: begin
            if (!in_rng(spx - 34'd1)) fault_r = 1'b1;
            if (y_ff == 32'd0) npc = CW'(rq_ff.operand);
            nsp = spx - 34'd1;
         end
         OP_SIO: begin
            case (rq_ff.operand)
               SIO_WRITE: begin
                  if (!in_rng(spx - 34'd1)) fault_r = 1'b1;
                  ov = 1'b1; oval = y_ff; nsp = spx - 34'd1;
               end
               SIO_READ: begin
                  if (!in_rng(spx + 34'd1)) fault_r = 1'b1;
                  nsp = spx + 34'd1; we = 1'b1; waddr = AW'(nsp);
                  wdata = rq_ff.read_value;
               end
               SIO_HALT: hlt = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
      // static link walk stopped at a bad link
      if ((rq_ff.opcode == OP_LOD || rq_ff.opcode == OP_STO || rq_ff.opcode == OP_CAL)
          && lev_ff != lev_cl) fault_r = 1'b1;
   end

   // CAL frame words, written one per cycle after commit
   logic [CW-1:0] ret_pc_ff;
   logic [AW-1:0] fbase_ff;
   logic [AW-1:0] oldbp_ff;
   logic [31:0]   fwv;
   always_comb begin
      case (wcnt_ff)
         2'd0:    fwv = 32'd0;
         2'd1:    fwv = b_ff[31:0];
         2'd2:    fwv = 32'(oldbp_ff);
         default: fwv = 32'(ret_pc_ff);
      endcase
   end

   logic fault;
   assign fault = fault_r || fault_d;

   // memory
   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdata_ff <= mem[raddr];
      if (cmd.clr_step) mem[AW'(clr_ff)] <= 32'd0;
      else if (cmd.wr_step) mem[fbase_ff + AW'(wcnt_ff)] <= fwv;
      else if (cmd.exec && !halt_ff && !fault && we) mem[waddr] <= wdata;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         bp_ff   <= AW'(1);
         sp_ff   <= '0;
         halt_ff <= 1'b0;
         clr_ff  <= '0;
         wcnt_ff <= 2'd0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + (AW+1)'(1);
         if (cmd.wr_step) wcnt_ff <= wcnt_ff + 2'd1;
         if (cmd.exec && !halt_ff) begin
            wcnt_ff <= 2'd0;
            if (fault) begin
               halt_ff <= 1'b1;
            end else begin
               pc_ff <= npc;
               sp_ff <= AW'(nsp);
               bp_ff <= AW'(nbp);
               if (hlt) halt_ff <= 1'b1;
            end
         end
      end
      if (cmd.exec) begin
         fbase_ff  <= sp_ff + AW'(1);
         oldbp_ff  <= bp_ff;
         ret_pc_ff <= pcn;
      end
      if (cmd.load) begin
         rq_ff  <= req;
         b_ff   <= bpx;
         lev_ff <= '0;
      end else if (cmd.cap == CP_X) begin
         x_ff <= rdata_ff;
      end else if (cmd.cap == CP_Y) begin
         y_ff <= rdata_ff;
      end else if (cmd.cap == CP_B) begin
         b_ff   <= {{2{rdata_ff[31]}}, rdata_ff};
         lev_ff <= lev_ff + LW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.next_pc    <= 9'(fault || halt_ff ? pc_ff : npc);
         rsp_ff.stack_top  <= 11'(fault || halt_ff ? spx : nsp);
         rsp_ff.frame_base <= 11'(fault || halt_ff ? bpx : nbp);
         rsp_ff.out_valid  <= !halt_ff && !fault && ov;
         rsp_ff.out_value  <= (!halt_ff && !fault && ov) ? oval : 32'd0;
         rsp_ff.halted     <= halt_ff || fault || hlt;
         rsp_ff.status     <= halt_ff ? ST_OK : (fault_r ? ST_RANGE :
                                                (fault_d ? ST_DIVZ : ST_OK));
      end
   end

   // status toward the controller
   assign sts.link_bad = (lev_ff != lev_cl) && !in_rng(b_ff + 34'd1);
   assign sts.div_busy = div_busy;
   assign sts.clr_done = (clr_ff == (AW+1)'(STACK_DEPTH));
   assign sts.wr_done  = (wcnt_ff == 2'd3);
   assign sts.halt     = halt_ff;
   assign rsp          = rsp_ff;
endmodule

// ===== hdl/pl0_ctrl.sv =====
// ----------------------------------------------------------------------------
// pl0_ctrl: p-machine sequencer
// Clears the stack after reset, then per item: walks static links, fetches
// operands, runs the divider, commits, writes CAL frames and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module pl0_ctrl import pl0_pkg::*; #(
   parameter int LEVELS = LEVELS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam int LW = $clog2(LEVELS + 1);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_WALK = 4'd2;
   localparam logic [3:0] S_WCAP = 4'd3;
   localparam logic [3:0] S_RDA  = 4'd4;
   localparam logic [3:0] S_CAPA = 4'd5;
   localparam logic [3:0] S_CAPB = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_DIVW = 4'd8;
   localparam logic [3:0] S_EXEC = 4'd9;
   localparam logic [3:0] S_FRM  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0]    state_ff, state_in;
   req_type       rq_ff;
   logic [LW-1:0] lev_ff, lev_in, lev_cl;
   logic          vld_ff, vld_in;
   logic          accept, is_walk, is_ret, is_bin, is_div, fault_walk_ff, fault_walk_in;

   assign lev_cl  = (32'(rq_ff.level) > 32'(LEVELS)) ? LW'(LEVELS) : LW'(rq_ff.level);
   assign is_walk = rq_ff.opcode == OP_LOD || rq_ff.opcode == OP_STO
                    || rq_ff.opcode == OP_CAL;
   assign is_ret  = rq_ff.opcode == OP_OPR && rq_ff.operand == OPR_RET;
   assign is_bin  = rq_ff.opcode == OP_OPR && rq_ff.operand >= OPR_ADD
                    && rq_ff.operand <= OPR_GEQ && rq_ff.operand != OPR_ODD;
   assign is_div  = is_bin && (rq_ff.operand == OPR_DIV || rq_ff.operand == OPR_MOD);

   assign accept    = (state_ff == S_IDLE) && req_valid && !vld_ff;
   assign req_stall = !((state_ff == S_IDLE) && !vld_ff);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in      = state_ff;
      lev_in        = lev_ff;
      vld_in        = vld_ff && rsp_stall;
      fault_walk_in = fault_walk_ff;
      cmd           = '0;
      cmd.rd_sel    = AS_SP;
      cmd.cap       = CP_NONE;
      unique case (state_ff)
         S_CLR: begin
            if (sts.clr_done) state_in = S_IDLE;
            else cmd.clr_step = 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load      = 1'b1;
               lev_in        = '0;
               fault_walk_in = 1'b0;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            // one static link per pass: read it here, capture it in S_WCAP
            if (sts.halt || !is_walk || lev_ff == lev_cl) begin
               state_in = S_RDA;
            end else if (sts.link_bad) begin
               fault_walk_in = 1'b1;
               state_in      = S_EXEC;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AS_LINK;
               state_in   = S_WCAP;
            end
         end
         S_WCAP: begin
            cmd.cap  = CP_B;
            lev_in   = lev_ff + LW'(1);
            state_in = S_WALK;
         end
         S_RDA: begin
            // first read: x side (second-from-top, or bp+2 for RET)
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = is_ret ? AS_BP2 : AS_SPM1;
            state_in   = S_CAPA;
         end
         S_CAPA: begin
            cmd.cap    = CP_X;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = is_ret ? AS_BP3 : AS_SP;
            state_in   = S_CAPB;
         end
         S_CAPB: begin
            cmd.cap = CP_Y;
            // LOD needs the loaded word in the read register at commit
            if (rq_ff.opcode == OP_LOD) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AS_BM;
            end
            state_in = (is_div && !sts.halt) ? S_DIV : S_EXEC;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!sts.div_busy) state_in = S_EXEC;
         end
         S_EXEC: begin
            // a bad link is flagged as a range fault by the datapath
            cmd.exec     = 1'b1;
            cmd.rsp_load = 1'b1;
            state_in     = (rq_ff.opcode == OP_CAL && !sts.halt && !fault_walk_ff)
                           ? S_FRM : S_OUT;
         end
         S_FRM: begin
            // CAL frame write; exec already set halt on a fault
            if (sts.halt) begin
               state_in = S_OUT;
            end else begin
               cmd.wr_step = 1'b1;
               if (sts.wr_done) state_in = S_OUT;
            end
         end
         S_OUT: begin
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         lev_ff        <= '0;
         vld_ff        <= 1'b0;
         fault_walk_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lev_ff        <= lev_in;
         vld_ff        <= vld_in;
         fault_walk_ff <= fault_walk_in;
      end
      if (accept) rq_ff <= req;
   end
endmodule

// ===== dv/pl0_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pl0_checker: result predictor and scoreboard for pl0_stack_machine_step
// Watches both channels, runs each accepted instruction item through a
// p-machine of its own and compares every result item, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
module pl0_checker import pl0_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int CODES = CODE_DEPTH_DEF;

   // machine state as seen by the predictor
   logic [31:0] mem [DEPTH];
   logic [8:0]  pc_q;
   logic [10:0] bp_q;
   logic [10:0] sp_q;
   logic        halt_q;

   rsp_type expq[$];

   function automatic bit in_stack(longint a);
      return a >= 0 && a < DEPTH;
   endfunction

   function automatic longint sx32(logic [31:0] w);
      return longint'($signed(w));
   endfunction

   // Execute one instruction; with commit low nothing is changed, which
   // lets the stimulus side look ahead for faults.
   function automatic rsp_type exec_instr(req_type r, bit commit);
      longint      sp, bp, b, nbp;
      logic [31:0] pcn, x, y, res, oval;
      logic [15:0] m;
      logic [1:0]  st;
      bit          ov, hlt, walk_ok;
      rsp_type     o;
      sp = sp_q;
      bp = bp_q;
      pcn = (pc_q + 32'd1) % CODES;
      m = r.operand;
      st = ST_OK;
      ov = 0;
      oval = '0;
      hlt = 0;
      b = 0;
      if (!halt_q) begin
         // static link walk for LOD, STO, CAL
         walk_ok = 1;
         b = bp;
         for (int i = 0; i < r.level; i++) begin
            if (walk_ok) begin
               if (!in_stack(b + 1)) walk_ok = 0;
               else b = sx32(mem[int'(b + 1)]);
            end
         end
         case (r.opcode)
            OP_LIT: begin
               if (!in_stack(sp + 1)) st = ST_RANGE;
               else begin
                  sp++;
                  if (commit) mem[int'(sp)] = 32'(m);
               end
            end
            OP_OPR: begin
               if (m == OPR_RET) begin
                  if (!in_stack(bp - 1) || !in_stack(bp + 3)) st = ST_RANGE;
                  else begin
                     nbp = sx32(mem[int'(bp + 2)]);
                     if (!in_stack(nbp)) st = ST_RANGE;
                     else begin
                        pcn = mem[int'(bp + 3)] % CODES;
                        sp = bp - 1;
                        bp = nbp;
                     end
                  end
               end else if (m == OPR_NEG) begin
                  if (commit) mem[int'(sp)] = 32'd0 - mem[int'(sp)];
               end else if (m == OPR_ODD) begin
                  if (commit) mem[int'(sp)] = mem[int'(sp)] & 32'd1;
               end else if (m <= OPR_GEQ) begin
                  if (!in_stack(sp - 1)) st = ST_RANGE;
                  else begin
                     x = mem[int'(sp - 1)];
                     y = mem[int'(sp)];
                     if ((m == OPR_DIV || m == OPR_MOD) && y == 0) st = ST_DIVZ;
                     else begin
                        case (m)
                           OPR_ADD: res = x + y;
                           OPR_SUB: res = x - y;
                           OPR_MUL: res = x * y;
                           OPR_DIV: res = 32'(sx32(x) / sx32(y));
                           OPR_MOD: res = 32'(sx32(x) % sx32(y));
                           OPR_EQL: res = 32'(sx32(x) == sx32(y));
                           OPR_NEQ: res = 32'(sx32(x) != sx32(y));
                           OPR_LSS: res = 32'(sx32(x) < sx32(y));
                           OPR_LEQ: res = 32'(sx32(x) <= sx32(y));
                           OPR_GTR: res = 32'(sx32(x) > sx32(y));
                           default: res = 32'(sx32(x) >= sx32(y));
                        endcase
                        sp--;
                        if (commit) mem[int'(sp)] = res;
                     end
                  end
               end
            end
            OP_LOD: begin
               if (!walk_ok || !in_stack(b + m) || !in_stack(sp + 1)) st = ST_RANGE;
               else begin
                  if (commit) mem[int'(sp + 1)] = mem[int'(b + m)];
                  sp++;
               end
            end
            OP_STO: begin
               if (!walk_ok || !in_stack(b + m) || !in_stack(sp - 1)) st = ST_RANGE;
               else begin
                  if (commit) mem[int'(b + m)] = mem[int'(sp)];
                  sp--;
               end
            end
            OP_CAL: begin
               if (!walk_ok || !in_stack(sp + 4)) st = ST_RANGE;
               else begin
                  if (commit) begin
                     mem[int'(sp + 1)] = '0;
                     mem[int'(sp + 2)] = b[31:0];
                     mem[int'(sp + 3)] = bp[31:0];
                     mem[int'(sp + 4)] = pcn;
                  end
                  bp = sp + 1;
                  pcn = m % CODES;
               end
            end
            OP_INC: begin
               if (!in_stack(sp + m)) st = ST_RANGE;
               else sp += m;
            end
            OP_JMP: pcn = m % CODES;
            OP_JPC: begin
               if (!in_stack(sp - 1)) st = ST_RANGE;
               else begin
                  if (mem[int'(sp)] == 0) pcn = m % CODES;
                  sp--;
               end
            end
            OP_SIO: begin
               if (m == SIO_WRITE) begin
                  if (!in_stack(sp - 1)) st = ST_RANGE;
                  else begin
                     ov = 1;
                     oval = mem[int'(sp)];
                     sp--;
                  end
               end else if (m == SIO_READ) begin
                  if (!in_stack(sp + 1)) st = ST_RANGE;
                  else begin
                     sp++;
                     if (commit) mem[int'(sp)] = r.read_value;
                  end
               end else if (m == SIO_HALT) begin
                  hlt = 1;
               end
            end
            default: ;
         endcase
      end
      // result from the registers after the instruction
      if (halt_q || st != ST_OK) begin
         o.next_pc = pc_q;
         o.stack_top = sp_q;
         o.frame_base = bp_q;
         o.out_valid = 0;
         o.out_value = '0;
         o.halted = 1;
      end else begin
         o.next_pc = pcn[8:0];
         o.stack_top = sp[10:0];
         o.frame_base = bp[10:0];
         o.out_valid = ov;
         o.out_value = oval;
         o.halted = hlt;
      end
      o.status = st;
      if (commit) begin
         pc_q = o.next_pc;
         sp_q = o.stack_top;
         bp_q = o.frame_base;
         halt_q = o.halted;
      end
      return o;
   endfunction

   task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) mem[i] = '0;
         pc_q = '0;
         bp_q = 11'd1;
         sp_q = '0;
         halt_q = 0;
         expq.delete();
      end else begin
         // compare an accepted result item
         if (rsp_valid && !rsp_stall) begin
            if (expq.size() == 0) begin
               errors++;
               $display("%0t: result item with none expected, actual %h", $time, rsp_data);
            end else begin
               e = expq.pop_front();
               cmp_field("next_pc", e.next_pc, rsp_data.next_pc);
               cmp_field("stack_top", e.stack_top, rsp_data.stack_top);
               cmp_field("frame_base", e.frame_base, rsp_data.frame_base);
               cmp_field("out_valid", e.out_valid, rsp_data.out_valid);
               cmp_field("out_value", e.out_value, rsp_data.out_value);
               cmp_field("halted", e.halted, rsp_data.halted);
               cmp_field("status", e.status, rsp_data.status);
            end
         end
         // predict an accepted instruction item
         if (req_valid && !req_stall) expq.push_back(exec_instr(req_data, 1'b1));
      end
      pending = expq.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for pl0_stack_machine_step
// Drives a directed instruction list, then random programs kept fault
// free by look-ahead in the checker, then one closing halt or fault.
// The receiver stalls in changing patterns; the checker scores results.
// ----------------------------------------------------------------------------
module tb;
   import pl0_pkg::*;

   localparam int RAND_ITEMS = 1350;
   localparam int CYCLE_LIMIT = 1000000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   int      cycles = 0;
   int      stall_mode = 0;

   pl0_stack_machine_step uut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   pl0_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .errors, .pending
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stall: the pattern is redrawn from time to time from four modes
   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   function automatic req_type mk(logic [3:0] op, logic [1:0] lev, logic [15:0] m,
                                  logic [31:0] rd);
      req_type r;
      r.opcode = op;
      r.level = lev;
      r.operand = m;
      r.read_value = rd;
      return r;
   endfunction

   function automatic logic [15:0] any16();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // one random instruction, not yet checked for faults
   function automatic req_type rand_instr();
      int          w;
      logic [3:0]  op;
      logic [15:0] m;
      logic [31:0] rd;
      w = $urandom_range(0, 99);
      if (w < 22) op = OP_LIT;
      else if (w < 50) op = OP_OPR;
      else if (w < 60) op = OP_LOD;
      else if (w < 68) op = OP_STO;
      else if (w < 74) op = OP_CAL;
      else if (w < 80) op = OP_INC;
      else if (w < 84) op = OP_JMP;
      else if (w < 90) op = OP_JPC;
      else if (w < 98) op = OP_SIO;
      else op = ($urandom_range(0, 1)) ? 4'd0 : 4'($urandom_range(10, 15));
      case (op)
         OP_LIT, OP_CAL, OP_JMP, OP_JPC: m = any16();
         OP_OPR: m = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(14, 65535))
                                                 : 16'($urandom_range(0, 13));
         OP_LOD, OP_STO: m = ($urandom_range(0, 9) == 0) ? any16()
                                                        : 16'($urandom_range(0, 6));
         OP_INC: m = ($urandom_range(0, 9) == 0) ? any16() : 16'($urandom_range(0, 4));
         OP_SIO: m = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(3, 65535))
                                                : 16'($urandom_range(0, 1));
         default: m = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: rd = 32'h8000_0000;
         1: rd = 32'h7FFF_FFFF;
         2: rd = 32'($signed($urandom_range(0, 20)) - 10);
         default: rd = $urandom;
      endcase
      return mk(op, 2'($urandom_range(0, 3)), m, rd);
   endfunction

   function automatic bit stops_machine(req_type r);
      rsp_type o;
      o = chk.exec_instr(r, 1'b0);
      return o.halted || o.status != ST_OK;
   endfunction

   // present one item and hold it until accepted
   task automatic send(req_type r);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      req_valid <= 0;
   endtask

   // gap before the next item; bursts use the shortest gap
   int burst_left = 0;
   task automatic gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end else begin
         burst_left--;
         @(posedge clock);
      end
   endtask

   req_type directed[$];
   req_type cand;
   int      tries;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed part: extremes, division wrap, odd of negative, frames
      directed = '{
         mk(OP_SIO, 0, SIO_READ, 32'h8000_0000), mk(OP_SIO, 0, SIO_READ, 32'hFFFF_FFFF),
         mk(OP_OPR, 0, OPR_DIV, 0), mk(OP_SIO, 0, SIO_READ, 32'hFFFF_FFFF),
         mk(OP_OPR, 0, OPR_MOD, 0), mk(OP_LIT, 0, 16'hFFFF, 0),
         mk(OP_OPR, 0, OPR_MUL, 0), mk(OP_SIO, 0, SIO_READ, 32'hFFFF_FFF9),
         mk(OP_OPR, 0, OPR_ODD, 0), mk(OP_OPR, 0, OPR_NEG, 0),
         mk(OP_OPR, 0, OPR_LSS, 0), mk(OP_LIT, 0, 16'd5, 0), mk(OP_LIT, 0, 16'd5, 0),
         mk(OP_OPR, 0, OPR_EQL, 0), mk(OP_CAL, 0, 16'd20, 0), mk(OP_INC, 0, 16'd4, 0),
         mk(OP_LOD, 1, 16'd0, 0), mk(OP_STO, 3, 16'd1, 0), mk(OP_CAL, 2, 16'hFFFF, 0),
         mk(OP_OPR, 0, OPR_RET, 0), mk(OP_JPC, 0, 16'd100, 0),
         mk(OP_JMP, 0, 16'hFFFF, 0), mk(4'd0, 0, 0, 0), mk(4'd15, 3, 16'hFFFF, 0),
         mk(OP_OPR, 0, 16'd14, 0), mk(OP_SIO, 0, 16'd3, 0), mk(OP_SIO, 0, SIO_WRITE, 0)
      };
      foreach (directed[i]) begin
         gap();
         if (!stops_machine(directed[i])) send(directed[i]);
      end

      // random programs with faults filtered out
      for (int n = 0; n < RAND_ITEMS; n++) begin
         gap();
         tries = 0;
         do begin
            cand = rand_instr();
            tries++;
         end while (stops_machine(cand) && tries < 50);
         if (stops_machine(cand)) cand = mk(OP_JMP, 0, 16'($urandom), $urandom);
         send(cand);
      end

      // closing: a halt, a zero divisor or a range fault, then ignored items
      gap();
      case ($urandom_range(0, 2))
         0: send(mk(OP_SIO, 0, SIO_HALT, 0));
         1: begin
            send(mk(OP_LIT, 0, 0, 0));
            gap();
            send(mk(OP_OPR, 0, ($urandom_range(0, 1)) ? OPR_DIV : OPR_MOD, 0));
         end
         default: send(mk(OP_INC, 0, 16'hFFFF, 0));
      endcase
      repeat (4) begin
         gap();
         send(rand_instr());
      end

      // drain
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
